@@ rtl/sioc_pkg.sv @@
// Shared constants, types and reset values of the super-I/O configuration decoder.
package sioc_pkg;

	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA  = 1'b1;

	localparam logic [7:0] KEY_ENTER = 8'h55;
	localparam logic [7:0] KEY_EXIT  = 8'hAA;

	localparam logic [7:0] REG_FDD      = 8'h00;
	localparam logic [7:0] REG_PORTS    = 8'h01;
	localparam logic [7:0] REG_SERIAL   = 8'h02;
	localparam logic [7:0] REG_FDD_MODE = 8'h05;
	localparam logic [7:0] REG_FDD_OPT  = 8'h07;

	localparam logic [7:0] REG5_MASK = 8'h7F;

	localparam logic [9:0] FDD_BASE_PRI = 10'h3F0;
	localparam logic [9:0] FDD_BASE_SEC = 10'h370;
	localparam logic [9:0] LPT_BASE_A   = 10'h3BC;
	localparam logic [9:0] LPT_BASE_B   = 10'h378;
	localparam logic [9:0] LPT_BASE_C   = 10'h278;
	localparam logic [9:0] COM1_BASE    = 10'h3F8;
	localparam logic [9:0] COM2_BASE    = 10'h2F8;

	typedef struct packed {
		logic [9:0] base;
		logic [3:0] irq;
	} sioc_serial_t;

	typedef struct packed {
		logic         unlock;
		logic [7:0]   index;
		logic [7:0]   reg1;
		logic [7:0]   reg2;
		logic [7:0]   reg5;
		logic [7:0]   reg7;
		logic [9:0]   com3;
		logic [9:0]   com4;
		logic [9:0]   floppy_base;
		logic [9:0]   par_base;
		logic [2:0]   par_irq;
		sioc_serial_t ser_a;
		sioc_serial_t ser_b;
		logic [7:0]   features;
	} sioc_state_t;

	typedef struct packed {
		logic         config_enabled;
		logic [9:0]   floppy_base;
		logic [9:0]   parallel_base;
		logic [2:0]   parallel_irq;
		sioc_serial_t ser_a;
		sioc_serial_t ser_b;
		logic [7:0]   floppy_features;
	} sioc_result_t;

	localparam sioc_state_t STATE_RESET = '{
		unlock:      1'b0,
		index:       8'h00,
		reg1:        8'h9F,
		reg2:        8'hDC,
		reg5:        8'h00,
		reg7:        8'h00,
		com3:        10'h338,
		com4:        10'h238,
		floppy_base: FDD_BASE_PRI,
		par_base:    LPT_BASE_C,
		par_irq:     3'd5,
		ser_a:       '{base: COM1_BASE, irq: 4'd4},
		ser_b:       '{base: COM2_BASE, irq: 4'd3},
		features:    8'h00
	};

endpackage

@@ rtl/sioc_wr_if.sv @@
// Bus write channel: one index-port or data-port write per item.
interface sioc_wr_if;
	logic       valid;
	logic       ready;
	logic       port_select;
	logic [7:0] write_data;

	modport source(output valid, port_select, write_data, input ready);
	modport sink(input valid, port_select, write_data, output ready);
endinterface

@@ rtl/sioc_res_if.sv @@
// Result channel: configuration state and decoded resources after each write.
interface sioc_res_if;
	logic       valid;
	logic       ready;
	logic       config_enabled;
	logic [9:0] floppy_base;
	logic [9:0] parallel_base;
	logic [2:0] parallel_irq;
	logic [9:0] serial_a_base;
	logic [3:0] serial_a_irq;
	logic [9:0] serial_b_base;
	logic [3:0] serial_b_irq;
	logic [7:0] floppy_features;

	modport source(output valid, config_enabled, floppy_base, parallel_base, parallel_irq,
		serial_a_base, serial_a_irq, serial_b_base, serial_b_irq, floppy_features,
		input ready);
	modport sink(input valid, config_enabled, floppy_base, parallel_base, parallel_irq,
		serial_a_base, serial_a_irq, serial_b_base, serial_b_irq, floppy_features,
		output ready);
endinterface

@@ rtl/superio_config_register_decoder.sv @@
// Top level of the super-I/O configuration port decoder.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------------
//  bus_wr   | in  | valid / ready | port_select (0 index, 1 data), write_data[7:0]
//  result   | out | valid / ready | config_enabled, floppy/parallel/serial decodes,
//           |     |               | floppy_features
//
// Each write item is captured in an input register, decoded combinationally and
// its result loaded into an output register; one item per cycle is sustained
// while the result side does not stall, set by the single decode stage.
// A stalled result holds the output register; the input stage still takes one
// more item and holds it until the output register frees.
// Reset (arst_n low) locks configuration, clears the index and restores the
// power-on register values and their decoded resources.
module superio_config_register_decoder import sioc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sioc_wr_if.sink    bus_wr,
	sioc_res_if.source result
);

	logic         valid_s1;
	logic         port_s1;
	logic [7:0]   data_s1;
	sioc_state_t  state_q;
	sioc_state_t  state_nxt;
	logic         res_valid_q;
	sioc_result_t res_q;
	logic         advance;

	// move the held item into the output register when that register is free or draining
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign bus_wr.ready = !valid_s1 || advance;

	// hold the input stage valid until its item advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bus_wr.ready) begin
			valid_s1 <= bus_wr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bus_wr.valid && bus_wr.ready) begin
			port_s1 <= bus_wr.port_select;
			data_s1 <= bus_wr.write_data;
		end
	end

	sioc_decode u_decode (
		.cur         (state_q),
		.port_select (port_s1),
		.write_data  (data_s1),
		.nxt         (state_nxt)
	);

	// commit the write to the register file only as its result is produced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// the result shows the state right after this write
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.config_enabled  <= state_nxt.unlock;
			res_q.floppy_base     <= state_nxt.floppy_base;
			res_q.parallel_base   <= state_nxt.par_base;
			res_q.parallel_irq    <= state_nxt.par_irq;
			res_q.ser_a           <= state_nxt.ser_a;
			res_q.ser_b           <= state_nxt.ser_b;
			res_q.floppy_features <= state_nxt.features;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.config_enabled  = res_q.config_enabled;
	assign result.floppy_base     = res_q.floppy_base;
	assign result.parallel_base   = res_q.parallel_base;
	assign result.parallel_irq    = res_q.parallel_irq;
	assign result.serial_a_base   = res_q.ser_a.base;
	assign result.serial_a_irq    = res_q.ser_a.irq;
	assign result.serial_b_base   = res_q.ser_b.base;
	assign result.serial_b_irq    = res_q.ser_b.irq;
	assign result.floppy_features = res_q.floppy_features;

endmodule

@@ rtl/sioc_decode.sv @@
// Next-state logic for one bus write: unlock, index load, register store and resource decode.
module sioc_decode import sioc_pkg::*; (
	input  sioc_state_t cur,
	input  logic        port_select,
	input  logic [7:0]  write_data,
	output sioc_state_t nxt
);

	function automatic logic [7:0] features(input logic [7:0] r1, input logic [7:0] r2,
		input logic [7:0] r5, input logic [7:0] r7);
		features = {r2[1], r1[5], r7[3:2], r7[1:0], r5[4:3]};
	endfunction

	function automatic sioc_serial_t serial(input logic [2:0] sel, input logic [9:0] com3,
		input logic [9:0] com4);
		sioc_serial_t s;
		s = '{base: 10'd0, irq: 4'd0};
		if (sel[2]) begin
			unique case (sel[1:0])
				2'd0: s = '{base: COM1_BASE, irq: 4'd4};
				2'd1: s = '{base: COM2_BASE, irq: 4'd3};
				2'd2: s = '{base: com3, irq: 4'd4};
				default: s = '{base: com4, irq: 4'd3};
			endcase
		end
		serial = s;
	endfunction

	logic [7:0] reg5_new;
	assign reg5_new = write_data & REG5_MASK;

	always_comb begin
		nxt = cur;
		if (port_select == PORT_DATA && cur.unlock) begin
			unique case (cur.index)
				REG_FDD: begin
					if (write_data[4])
						nxt.floppy_base = cur.reg5[0] ? FDD_BASE_SEC : FDD_BASE_PRI;
					else
						nxt.floppy_base = 10'd0;
					nxt.features = features(cur.reg1, cur.reg2, cur.reg5, cur.reg7);
				end
				REG_PORTS: begin
					nxt.reg1 = write_data;
					unique case (write_data[6:5])
						2'd0: begin nxt.com3 = 10'h338; nxt.com4 = 10'h238; end
						2'd1: begin nxt.com3 = 10'h3E8; nxt.com4 = 10'h2E8; end
						2'd2: begin nxt.com3 = 10'h2E8; nxt.com4 = 10'h2E0; end
						default: begin nxt.com3 = 10'h220; nxt.com4 = 10'h228; end
					endcase
					unique case (write_data[1:0])
						2'd1: begin nxt.par_base = LPT_BASE_A; nxt.par_irq = 3'd7; end
						2'd2: begin nxt.par_base = LPT_BASE_B; nxt.par_irq = 3'd7; end
						2'd3: begin nxt.par_base = LPT_BASE_C; nxt.par_irq = 3'd5; end
						default: begin nxt.par_base = 10'd0; nxt.par_irq = 3'd0; end
					endcase
				end
				REG_SERIAL: begin
					nxt.reg2 = write_data;
					nxt.ser_a = serial(write_data[2:0], cur.com3, cur.com4);
					nxt.ser_b = serial(write_data[6:4], cur.com3, cur.com4);
					nxt.features = features(cur.reg1, write_data, cur.reg5, cur.reg7);
				end
				REG_FDD_MODE: begin
					nxt.reg5 = reg5_new;
					nxt.features = features(cur.reg1, cur.reg2, reg5_new, cur.reg7);
				end
				REG_FDD_OPT: begin
					nxt.reg7 = write_data;
					nxt.features = features(cur.reg1, cur.reg2, cur.reg5, write_data);
				end
				// other registers never reach a decoded output: drop the write
				default: ;
			endcase
		end else begin
			nxt.index = write_data;
			if (write_data == KEY_ENTER || write_data == KEY_EXIT)
				nxt.unlock = write_data[0];
		end
	end

endmodule

@@ rtl/sioc_checker.sv @@
// Port-level checks of the configuration decoder and their bind to the top level.
module sioc_checker import sioc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic       config_enabled,
	input logic [9:0] floppy_base,
	input logic [9:0] parallel_base,
	input logic [2:0] parallel_irq,
	input logic [9:0] serial_a_base,
	input logic [3:0] serial_a_irq,
	input logic [9:0] serial_b_base,
	input logic [3:0] serial_b_irq,
	input logic [7:0] floppy_features
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable({config_enabled, floppy_base, parallel_base,
			parallel_irq, serial_a_base, serial_a_irq, serial_b_base, serial_b_irq,
			floppy_features}))
		else $error("result changed while stalled");

	a_floppy_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (floppy_base == 10'd0 || floppy_base == FDD_BASE_PRI ||
			floppy_base == FDD_BASE_SEC))
		else $error("floppy base outside its decode set");

	a_lpt_pair: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> ((parallel_base == 10'd0) == (parallel_irq == 3'd0)))
		else $error("parallel base and irq disagree on enable");

	a_ser_a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> ((serial_a_base == 10'd0) == (serial_a_irq == 4'd0)))
		else $error("serial A base and irq disagree on enable");

	a_ser_b_pair: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> ((serial_b_base == 10'd0) == (serial_b_irq == 4'd0)))
		else $error("serial B base and irq disagree on enable");

endmodule

bind superio_config_register_decoder sioc_checker u_sioc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.valid           (result.valid),
	.ready           (result.ready),
	.config_enabled  (result.config_enabled),
	.floppy_base     (result.floppy_base),
	.parallel_base   (result.parallel_base),
	.parallel_irq    (result.parallel_irq),
	.serial_a_base   (result.serial_a_base),
	.serial_a_irq    (result.serial_a_irq),
	.serial_b_base   (result.serial_b_base),
	.serial_b_irq    (result.serial_b_irq),
	.floppy_features (result.floppy_features)
);

@@ test/superio_config_register_decoder_tb.sv @@
// Testbench for the super-I/O configuration port decoder: directed and random bus writes.
module superio_config_register_decoder_tb import sioc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CFG_REG_COUNT = 16;
	localparam int unsigned RANDOM_WRITES = 1500;
	localparam int unsigned PHASE_LEN     = 100;

	// Registers that only hold a byte: 3, 4, 6, 8-0xA and 0xF.
	localparam logic [15:0] STORE_ONLY_MASK = 16'h8758;
	localparam logic [7:0]  REG_SPARE       = 8'h0F;
	localparam logic [7:0]  REG_RESERVED    = 8'h0B;

	// Registers whose writes refresh the latched resource decodes.
	localparam logic [7:0] DECODED_REGS [5] = '{REG_FDD, REG_PORTS, REG_SERIAL,
		REG_FDD_MODE, REG_FDD_OPT};

	typedef struct {
		logic       port;
		logic [7:0] data;
	} bus_write_t;

	// Tracks the register file and latched decodes, and holds the decode expected
	// for every accepted write until the matching result comes out.
	class superio_decode_tracker;
		logic [7:0]   regs [CFG_REG_COUNT];
		logic [7:0]   index;
		logic         unlock;
		logic [9:0]   com3;
		logic [9:0]   com4;
		sioc_result_t latched;
		sioc_result_t pending_decodes [$];
		int unsigned  errors;
		int unsigned  checked;
		int unsigned  stores;
		int unsigned  ignored;
		int unsigned  lock_changes;

		function new();
			foreach (regs[i])
				regs[i] = 8'h00;
			regs[REG_FDD]    = 8'h3B;
			regs[REG_PORTS]  = STATE_RESET.reg1;
			regs[REG_SERIAL] = STATE_RESET.reg2;
			regs[3]          = 8'h78;
			regs[6]          = 8'hFF;
			regs[13]         = 8'h65;
			index   = STATE_RESET.index;
			unlock  = 1'b0;
			latched = '0;
			decode_floppy();
			decode_pair();
			decode_parallel();
			decode_serial(0);
			decode_serial(1);
			decode_features();
		endfunction

		function void decode_floppy();
			logic [9:0] base;
			base = regs[REG_FDD_MODE][0] ? FDD_BASE_SEC : FDD_BASE_PRI;
			latched.floppy_base = regs[REG_FDD][4] ? base : 10'h000;
		endfunction

		function void decode_pair();
			case (regs[REG_PORTS][6:5])
				2'd0: begin
					com3 = 10'h338; com4 = 10'h238;
				end
				2'd1: begin
					com3 = 10'h3E8; com4 = 10'h2E8;
				end
				2'd2: begin
					com3 = 10'h2E8; com4 = 10'h2E0;
				end
				default: begin
					com3 = 10'h220; com4 = 10'h228;
				end
			endcase
		endfunction

		function void decode_parallel();
			case (regs[REG_PORTS][1:0])
				2'd1: begin
					latched.parallel_base = LPT_BASE_A; latched.parallel_irq = 3'd7;
				end
				2'd2: begin
					latched.parallel_base = LPT_BASE_B; latched.parallel_irq = 3'd7;
				end
				2'd3: begin
					latched.parallel_base = LPT_BASE_C; latched.parallel_irq = 3'd5;
				end
				default: begin
					latched.parallel_base = 10'h000; latched.parallel_irq = 3'd0;
				end
			endcase
		endfunction

		function void decode_serial(int unsigned which);
			logic [3:0]   sel;
			sioc_serial_t port;
			sel  = which ? regs[REG_SERIAL][7:4] : regs[REG_SERIAL][3:0];
			port = '0;
			if (sel[2]) begin
				case (sel[1:0])
					2'd0: port = '{base: COM1_BASE, irq: 4'd4};
					2'd1: port = '{base: COM2_BASE, irq: 4'd3};
					2'd2: port = '{base: com3, irq: 4'd4};
					default: port = '{base: com4, irq: 4'd3};
				endcase
			end
			if (which)
				latched.ser_b = port;
			else
				latched.ser_a = port;
		endfunction

		function void decode_features();
			latched.floppy_features = {regs[REG_SERIAL][1], regs[REG_PORTS][5],
				regs[REG_FDD_OPT][3:2], regs[REG_FDD_OPT][1:0], regs[REG_FDD_MODE][4:3]};
		endfunction

		// Apply one accepted bus write and queue the decode it should produce.
		function void note_write(logic port, logic [7:0] value);
			logic was_unlocked;
			was_unlocked = unlock;
			if (port == PORT_DATA && unlock) begin
				case (index)
					REG_FDD: begin
						regs[REG_FDD] = value;
						decode_floppy();
						decode_features();
						stores++;
					end
					REG_PORTS: begin
						regs[REG_PORTS] = value;
						decode_pair();
						decode_parallel();
						stores++;
					end
					REG_SERIAL: begin
						regs[REG_SERIAL] = value;
						decode_serial(0);
						decode_serial(1);
						decode_features();
						stores++;
					end
					REG_FDD_MODE: begin
						regs[REG_FDD_MODE] = value & REG5_MASK;
						decode_features();
						stores++;
					end
					REG_FDD_OPT: begin
						regs[REG_FDD_OPT] = value;
						decode_features();
						stores++;
					end
					default: begin
						if (index < CFG_REG_COUNT && STORE_ONLY_MASK[index[3:0]]) begin
							regs[index[3:0]] = value;
							stores++;
						end else begin
							ignored++;
						end
					end
				endcase
			end else begin
				index = value;
				if (value == KEY_ENTER || value == KEY_EXIT)
					unlock = value[0];
			end
			if (unlock != was_unlocked)
				lock_changes++;
			latched.config_enabled = unlock;
			pending_decodes.push_back(latched);
		endfunction

		function void compare(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, field, want, got);
				errors++;
			end
		endfunction

		// Match one result against the oldest queued decode.
		function void check_decode(sioc_result_t got);
			sioc_result_t want;
			if (pending_decodes.size() == 0) begin
				$display("%0t ns: result 0x%0h arrived with no write pending", $time, got);
				errors++;
				return;
			end
			want = pending_decodes.pop_front();
			checked++;
			compare("config_enabled", want.config_enabled, got.config_enabled);
			compare("floppy_base", want.floppy_base, got.floppy_base);
			compare("parallel_base", want.parallel_base, got.parallel_base);
			compare("parallel_irq", want.parallel_irq, got.parallel_irq);
			compare("serial_a_base", want.ser_a.base, got.ser_a.base);
			compare("serial_a_irq", want.ser_a.irq, got.ser_a.irq);
			compare("serial_b_base", want.ser_b.base, got.ser_b.base);
			compare("serial_b_irq", want.ser_b.irq, got.ser_b.irq);
			compare("floppy_features", want.floppy_features, got.floppy_features);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sioc_wr_if  bus_wr();
	sioc_res_if result();

	superio_config_register_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.bus_wr(bus_wr),
		.result(result)
	);

	superio_decode_tracker tracker = new();

	// When set, both sides run back to back with no idle cycles.
	bit steady = 1'b0;
	int unsigned writes_sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned draw_gap();
		return steady ? 0 : $urandom_range(0, 3);
	endfunction

	// Lean toward the extreme bytes so every field sees its corners often.
	function automatic logic [7:0] pick_byte();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 8'h00;
		if (roll == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Drive one bus write: idle for a drawn gap, then hold the item until it is taken.
	task automatic send_write(input logic port, input logic [7:0] data);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			bus_wr.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bus_wr.valid       <= 1'b1;
		bus_wr.port_select <= port;
		bus_wr.write_data  <= data;
		// Sample ready as it stood before the edge; the item moves on the edge where it is high.
		do @(posedge clk); while (!bus_wr.ready);
		tracker.note_write(port, data);
		writes_sent++;
	endtask

	// Result side: stall for a drawn gap per item, then take the next result.
	initial begin
		sioc_result_t got;
		int unsigned  stall;
		result.ready <= 1'b0;
		// hold off until reset has released so no unknown valid is sampled
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap();
			if (stall != 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (result.valid !== 1'b1);
			got.config_enabled  = result.config_enabled;
			got.floppy_base     = result.floppy_base;
			got.parallel_base   = result.parallel_base;
			got.parallel_irq    = result.parallel_irq;
			got.ser_a.base      = result.serial_a_base;
			got.ser_a.irq       = result.serial_a_irq;
			got.ser_b.base      = result.serial_b_base;
			got.ser_b.irq       = result.serial_b_irq;
			got.floppy_features = result.floppy_features;
			tracker.check_decode(got);
		end
	end

	// Stimulus: directed corners first, then random index/data sequences.
	initial begin
		bus_write_t directed [25] = '{
			'{PORT_DATA,  8'h12},        // data write while locked lands in the index
			'{PORT_INDEX, KEY_EXIT},     // lock key while already locked
			'{PORT_DATA,  KEY_ENTER},    // data write of the unlock key while locked
			'{PORT_INDEX, REG_FDD},
			'{PORT_DATA,  8'h00},        // floppy disabled
			'{PORT_DATA,  8'hFF},        // floppy back on at the primary base
			'{PORT_INDEX, REG_FDD_MODE},
			'{PORT_DATA,  8'hFF},        // top bit dropped by the mask
			'{PORT_INDEX, REG_FDD},
			'{PORT_DATA,  8'h10},        // floppy base now follows the secondary select
			'{PORT_INDEX, REG_PORTS},
			'{PORT_DATA,  8'h00},        // parallel off, first COM3/COM4 pair
			'{PORT_DATA,  8'hFF},        // last pair, parallel at its third base
			'{PORT_INDEX, REG_SERIAL},
			'{PORT_DATA,  8'h00},        // both serial ports disabled
			'{PORT_DATA,  8'hFF},        // both serial ports on the COM4 address
			'{PORT_INDEX, REG_FDD_OPT},
			'{PORT_DATA,  8'hFF},
			'{PORT_INDEX, REG_SPARE},
			'{PORT_DATA,  8'hA5},        // store-only register
			'{PORT_INDEX, REG_RESERVED},
			'{PORT_DATA,  8'h5A},        // unwritable register, dropped
			'{PORT_INDEX, KEY_ENTER},    // unlock key while unlocked
			'{PORT_INDEX, KEY_EXIT},     // lock
			'{PORT_DATA,  8'hFF}         // locked again, taken as an index
		};
		int unsigned target;
		int unsigned next_phase;
		int unsigned roll;
		logic [7:0]  idx;

		bus_wr.valid       <= 1'b0;
		bus_wr.port_select <= PORT_INDEX;
		bus_wr.write_data  <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_write(directed[i].port, directed[i].data);

		target     = writes_sent + RANDOM_WRITES;
		next_phase = writes_sent;
		while (writes_sent < target) begin
			// Switch idle behavior every phase; about a quarter of phases run with no gaps.
			if (writes_sent >= next_phase) begin
				steady     = ($urandom_range(0, 3) == 0);
				next_phase = writes_sent + PHASE_LEN;
			end
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				// Well-formed sequence: unlock if needed, select a register, write it.
				if (!tracker.unlock)
					send_write(PORT_INDEX, KEY_ENTER);
				roll = $urandom_range(0, 9);
				if (roll < 7)
					idx = DECODED_REGS[$urandom_range(0, 4)];
				else if (roll < 9)
					idx = 8'($urandom_range(0, CFG_REG_COUNT - 1));
				else
					idx = 8'($urandom_range(0, 255));
				send_write(PORT_INDEX, idx);
				repeat ($urandom_range(1, 2))
					send_write(PORT_DATA, pick_byte());
			end else if (roll < 78) begin
				send_write(PORT_INDEX, KEY_EXIT);
			end else begin
				// Noise: any port, any byte, with the unlock key now and then.
				send_write(1'($urandom_range(0, 1)),
					($urandom_range(0, 3) == 0) ? KEY_ENTER : pick_byte());
			end
		end
		bus_wr.valid <= 1'b0;

		// Drain outstanding results, then leave room for any stray one.
		while (tracker.pending_decodes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Drove %0d bus writes: %0d register stores, %0d ignored data writes, %0d lock changes.",
			writes_sent, tracker.stores, tracker.ignored, tracker.lock_changes);
		$display("Compared %0d decode results field by field, %0d mismatches.",
			tracker.checked, tracker.errors);
		if (tracker.errors == 0 && tracker.pending_decodes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/sioc_pkg.sv
rtl/sioc_wr_if.sv
rtl/sioc_res_if.sv
rtl/sioc_decode.sv
rtl/superio_config_register_decoder.sv
rtl/sioc_checker.sv
test/superio_config_register_decoder_tb.sv
